FILE: rtl/palette_run_length_pixel_decoder_top_macros.svh
// Assertion macros for the palette run-length pixel decoder.
// Used by the top level only; no other dependencies.
`ifndef PALETTE_RUN_LENGTH_PIXEL_DECODER_TOP_MACROS_SVH
`define PALETTE_RUN_LENGTH_PIXEL_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PRLPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PRLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PRLPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PRLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/prlpd_pkg.sv
// Shared constants, types and the index mask table of the pixel decoder.
// No dependencies.
package prlpd_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SLOTS = 4;
	localparam int PIXELS_PER_RESULT = 4;
	localparam int GROUP = (PIXELS_PER_RESULT > SLOTS) ? SLOTS : PIXELS_PER_RESULT;
	localparam int COLOR_W = 16;
	localparam int COUNT_W = 8;
	localparam int TAKE_W = 3;

	localparam logic CFG_PIXEL_BITS = 1'b0;
	localparam logic CFG_COMPRESSED = 1'b1;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_STREAM = 1'b1;

	typedef struct packed {
		logic               start;
		logic               in_range;
		logic [COUNT_W-1:0] count;
	} run_req_t;

	typedef struct packed {
		logic busy;
		logic emitting;
	} seq_status_t;

	function automatic logic [7:0] index_mask(input logic [3:0] bits);
		logic [7:0] m;
		unique case (bits)
			4'd0: m = 8'h00;
			4'd1: m = 8'h01;
			4'd2: m = 8'h03;
			4'd3: m = 8'h07;
			4'd4: m = 8'h0F;
			4'd5: m = 8'h1F;
			4'd6: m = 8'h3F;
			4'd7: m = 8'h7F;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/prlpd_palette_ram.sv
// Palette store: one write port, one registered read port.
// No dependencies.
module prlpd_palette_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/prlpd_run_seq.sv
// Run sequencer: takes up to four pixels per pass off the run count with one
// shared compare/subtract unit and drives the output register. Uses prlpd_pkg.
module prlpd_run_seq
	import prlpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  run_req_t           req,
	input  logic [COLOR_W-1:0] rdata,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [COLOR_W-1:0] pix [SLOTS],
	output logic [TAKE_W-1:0]  pix_count,
	output logic               run_end,
	output seq_status_t        status
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               in_range_q;
	logic [COLOR_W-1:0] color_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] pix_q [SLOTS];
	logic [TAKE_W-1:0]  count_q;
	logic               run_end_q;

	logic [TAKE_W-1:0]  take;
	logic [COUNT_W-1:0] rem;
	logic               load;

	// shared unit: clamp and subtract
	assign take = (cnt_q > COUNT_W'(GROUP)) ? TAKE_W'(GROUP) : cnt_q[TAKE_W-1:0];
	assign rem = cnt_q - {{(COUNT_W-TAKE_W){1'b0}}, take};
	assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && rem == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			cnt_q <= req.count;
			in_range_q <= req.in_range;
		end
		if (state_q == ST_READ) begin
			color_q <= in_range_q ? {rdata[7:0], rdata[15:8]} : '0;
		end
		if (load) begin
			cnt_q <= rem;
			count_q <= take;
			run_end_q <= (rem == '0);
			for (int s = 0; s < SLOTS; s++) begin
				pix_q[s] <= (s < int'(take)) ? color_q : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pix = pix_q;
	assign pix_count = count_q;
	assign run_end = run_end_q;
	assign status.busy = (state_q != ST_IDLE);
	assign status.emitting = (state_q == ST_EMIT);

endmodule

FILE: rtl/palette_run_length_pixel_decoder_top.sv
// Palette run-length pixel decoder: byte framing, palette store, run sequencer.
// The first group of a run passes the palette read register, the color register
// and the output register. Palette writes and held bytes do not stall the input;
// a run keeps the input stalled through the read state and its emit state, one
// group per cycle out while the output is not stalled.
// Reset clears control state and registers (pixel_bits 8, compressed 0);
// the palette is not cleared and needs no clearing pass.
`include "palette_run_length_pixel_decoder_top_macros.svh"

module palette_run_length_pixel_decoder_top
	import prlpd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [3:0]               cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic [7:0]               palette_index,
	input  logic [COLOR_W-1:0]       palette_color,
	input  logic [7:0]               stream_byte,
	input  logic                     final_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [COLOR_W-1:0]       pixel_a,
	output logic [COLOR_W-1:0]       pixel_b,
	output logic [COLOR_W-1:0]       pixel_c,
	output logic [COLOR_W-1:0]       pixel_d,
	output logic [TAKE_W-1:0]        pixel_count,
	output logic                     run_end
);

	logic [3:0]   pixel_bits_q;
	logic         compressed_q;
	logic [7:0]   held_q;
	logic         phase_q;

	logic         accept;
	logic         two_byte;
	logic [3:0]   eff_bits;
	logic [7:0]   idx;
	logic [7:0]   count;
	logic         decode_go;
	run_req_t     req;
	seq_status_t  status;
	logic [COLOR_W-1:0] rdata;
	logic [COLOR_W-1:0] pix [SLOTS];

	assign accept = in_valid && !in_stall;
	assign in_stall = status.busy;
	assign two_byte = (pixel_bits_q >= 4'd8) && compressed_q;
	assign eff_bits = (pixel_bits_q > 4'd8) ? 4'd8 : pixel_bits_q;

	always_comb begin
		if (two_byte) begin
			idx = stream_byte;
			count = held_q;
		end else begin
			idx = stream_byte & index_mask(eff_bits);
			count = stream_byte >> eff_bits;
		end
	end

	assign decode_go = accept && (kind == KIND_STREAM) && (!two_byte || phase_q);
	assign req.start = decode_go && (count != '0);
	assign req.in_range = (int'(idx) < PALETTE_DEPTH);
	assign req.count = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q <= 4'd8;
			compressed_q <= 1'b0;
			held_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PIXEL_BITS: pixel_bits_q <= cfg_data;
					CFG_COMPRESSED: compressed_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && kind == KIND_STREAM) begin
				if (!two_byte || phase_q) begin
					phase_q <= 1'b0;
				end else begin
					held_q <= stream_byte;
					phase_q <= !final_byte;
				end
			end
		end
	end

	prlpd_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.WIDTH (COLOR_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && kind == KIND_PALETTE && int'(palette_index) < PALETTE_DEPTH),
		.waddr (palette_index[ADDR_W-1:0]),
		.wdata (palette_color),
		.raddr (idx[ADDR_W-1:0]),
		.rdata (rdata)
	);

	prlpd_run_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rdata     (rdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.pix       (pix),
		.pix_count (pixel_count),
		.run_end   (run_end),
		.status    (status)
	);

	assign pixel_a = pix[0];
	assign pixel_b = pix[1];
	assign pixel_c = pix[2];
	assign pixel_d = pix[3];

	`PRLPD_ASSERT_NOW(a_count_range, clk, arst_n, out_valid, pixel_count != 3'd0 && pixel_count <= 3'd4)
	`PRLPD_ASSERT_NOW(a_more_groups, clk, arst_n, out_valid && !run_end, status.emitting)
	`PRLPD_ASSERT_NEXT(a_run_starts, clk, arst_n, req.start, in_stall && !status.emitting)
	`PRLPD_ASSERT_NOW(a_short_group_ends, clk, arst_n, out_valid && pixel_count != 3'd4, run_end)

endmodule

FILE: tb/palette_run_length_pixel_decoder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the palette run-length pixel decoder: mirrors the register writes,
// predicts the pixel groups of every accepted request and checks the output channel.
// Depends on prlpd_pkg for the register indexes, request kinds and group size.
module palette_run_length_pixel_decoder_checker
	import prlpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [3:0]           cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 kind,
	input  logic [7:0]           palette_index,
	input  logic [COLOR_W-1:0]   palette_color,
	input  logic [7:0]           stream_byte,
	input  logic                 final_byte,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [COLOR_W-1:0]   pixel_a,
	input  logic [COLOR_W-1:0]   pixel_b,
	input  logic [COLOR_W-1:0]   pixel_c,
	input  logic [COLOR_W-1:0]   pixel_d,
	input  logic [TAKE_W-1:0]    pixel_count,
	input  logic                 run_end,
	output int                   fail_count,
	output int                   pending_groups
);

	typedef struct packed {
		logic [3:0][15:0] pix;
		logic [2:0]       count;
		logic             run_end;
	} pixel_group_t;

	pixel_group_t expected_groups[$];
	logic [15:0]  palette_copy [256];
	logic [3:0]   idx_bits;
	logic         compressed_sel;
	logic [7:0]   held_byte;
	logic         pair_open;

	function automatic void queue_run(logic [15:0] block);
		logic [3:0]   bits;
		logic [7:0]   mask;
		logic [15:0]  color;
		int unsigned  remaining;
		int unsigned  take;
		pixel_group_t grp;
		bits = (idx_bits > 4'd8) ? 4'd8 : idx_bits;
		mask = 8'((16'd1 << bits) - 16'd1);
		color = palette_copy[block[7:0] & mask];
		remaining = (block >> bits) & 16'h00FF;
		while (remaining != 0) begin
			take = (remaining > GROUP) ? GROUP : remaining;
			remaining -= take;
			for (int s = 0; s < 4; s++)
				grp.pix[s] = (s < take) ? {color[7:0], color[15:8]} : 16'h0000;
			grp.count = 3'(take);
			grp.run_end = (remaining == 0);
			expected_groups.push_back(grp);
		end
	endfunction

	function automatic void decode_request();
		if (kind == KIND_PALETTE) begin
			palette_copy[palette_index] = palette_color;
		end else if (!(idx_bits >= 4'd8 && compressed_sel)) begin
			pair_open = 1'b0;
			queue_run({8'h00, stream_byte});
		end else if (!pair_open) begin
			held_byte = stream_byte;
			pair_open = !final_byte;
		end else begin
			pair_open = 1'b0;
			queue_run({held_byte, stream_byte});
		end
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_group_t want;
		if (!arst_n) begin
			idx_bits = 4'd8;
			compressed_sel = 1'b0;
			held_byte = 8'h00;
			pair_open = 1'b0;
			fail_count = 0;
			expected_groups.delete();
			pending_groups <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_groups.size() == 0) begin
					$error("pixel group with no request pending: pixel_a %0h count %0d",
						pixel_a, pixel_count);
					fail_count++;
				end else begin
					want = expected_groups.pop_front();
					check_field("pixel_a", want.pix[0], pixel_a);
					check_field("pixel_b", want.pix[1], pixel_b);
					check_field("pixel_c", want.pix[2], pixel_c);
					check_field("pixel_d", want.pix[3], pixel_d);
					check_field("pixel_count", want.count, pixel_count);
					check_field("run_end", want.run_end, run_end);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PIXEL_BITS)
					idx_bits = cfg_data;
				else
					compressed_sel = cfg_data[0];
			end
			if (in_valid && !in_stall)
				decode_request();
			pending_groups <= expected_groups.size();
		end
	end

endmodule

FILE: tb/palette_run_length_pixel_decoder_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the palette run-length pixel decoder: clock, reset, register
// writes, directed and random requests, output stall pattern and the verdict.
// Depends on prlpd_pkg, the decoder RTL and palette_run_length_pixel_decoder_checker.
module palette_run_length_pixel_decoder_top_tb;
	import prlpd_pkg::*;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 17;
	localparam int HOLD_PHASE = 1;
	// pixel_bits and compressed per random phase, phase 0 in the low slot
	localparam logic [PHASES-1:0][3:0] PHASE_BITS =
		{4'd8, 4'd9, 4'd6, 4'd15, 4'd4, 4'd2, 4'd0, 4'd8};
	localparam logic [PHASES-1:0] PHASE_COMP = 8'b1001_1001;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_PIXEL_BITS;
	logic [3:0]         cfg_data = 4'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_PALETTE;
	logic [7:0]         palette_index = 8'd0;
	logic [COLOR_W-1:0] palette_color = '0;
	logic [7:0]         stream_byte = 8'd0;
	logic               final_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COLOR_W-1:0] pixel_a;
	logic [COLOR_W-1:0] pixel_b;
	logic [COLOR_W-1:0] pixel_c;
	logic [COLOR_W-1:0] pixel_d;
	logic [TAKE_W-1:0]  pixel_count;
	logic               run_end;
	int                 fail_count;
	int                 pending_groups;

	bit                 written [256];
	logic [3:0]         cur_bits = 4'd8;
	logic               cur_comp = 1'b0;
	logic               pair_open = 1'b0;
	bit                 hold_req = 1'b0;
	bit                 hold_done = 1'b0;
	int                 hold_left = 0;
	int                 seg_left = 0;
	stall_mode_t        stall_mode = STALL_NONE;
	int                 cycle_count = 0;

	palette_run_length_pixel_decoder_top DUT (.*);
	palette_run_length_pixel_decoder_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// output side: random stall segments, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left <= $urandom_range(150, 20);
				stall_mode <= stall_mode_t'($urandom_range(3, 0));
			end else begin
				seg_left <= seg_left - 1;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(9, 0) < 7);
				default: out_stall <= (seg_left % 3 == 0);
			endcase
		end
	end

	task automatic send_request(logic k, logic [7:0] pidx, logic [15:0] pcol,
			logic [7:0] sbyte, logic fin);
		in_valid <= 1'b1;
		kind <= k;
		palette_index <= pidx;
		palette_color <= pcol;
		stream_byte <= sbyte;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		if (k == KIND_PALETTE)
			written[pidx] = 1'b1;
		else if (cur_bits >= 4'd8 && cur_comp && !pair_open)
			pair_open = !fin;
		else
			pair_open = 1'b0;
	endtask

	task automatic pal(logic [7:0] pidx, logic [15:0] pcol);
		send_request(KIND_PALETTE, pidx, pcol, 8'($urandom), 1'($urandom));
	endtask

	task automatic stream(logic [7:0] sbyte, logic fin);
		send_request(KIND_STREAM, 8'($urandom), 16'($urandom), sbyte, fin);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_groups != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(logic [3:0] bits, logic comp);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PIXEL_BITS;
		cfg_data <= bits;
		@(posedge clk);
		cfg_index <= CFG_COMPRESSED;
		cfg_data <= {3'b000, comp};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_bits = bits;
		cur_comp = comp;
	endtask

	// mostly short runs, now and then anything the field allows
	function automatic int unsigned pick_count(int unsigned width);
		int unsigned maxc;
		if (width == 0)
			return 0;
		maxc = (1 << width) - 1;
		if ($urandom_range(7, 0) == 0)
			return $urandom_range(maxc, 0);
		return $urandom_range((maxc < 12) ? maxc : 12, 0);
	endfunction

	// palette entries are only read once written; entry 0 always is
	function automatic logic [7:0] pick_entry(logic [7:0] mask);
		logic [7:0] idx;
		repeat (32) begin
			idx = 8'($urandom) & mask;
			if (written[idx])
				return idx;
		end
		return 8'h00;
	endfunction

	task automatic random_request();
		logic [3:0] bits;
		logic [7:0] mask;
		logic [7:0] sbyte;
		logic       fin;
		if ($urandom_range(4, 0) == 0) begin
			pal(8'($urandom), 16'($urandom));
		end else if (cur_bits >= 4'd8 && cur_comp) begin
			if (pair_open) begin
				sbyte = pick_entry(8'hFF);
				fin = 1'($urandom);
			end else begin
				sbyte = 8'(pick_count(8));
				fin = ($urandom_range(9, 0) == 0);
			end
			stream(sbyte, fin);
		end else begin
			bits = (cur_bits > 4'd8) ? 4'd8 : cur_bits;
			mask = 8'((16'd1 << bits) - 16'd1);
			sbyte = 8'((pick_count(8 - bits) << bits) | pick_entry(mask));
			fin = ($urandom_range(3, 0) == 0);
			stream(sbyte, fin);
		end
	endtask

	initial begin
		int unsigned burst_left;
		bit          gaps_on;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mode: one-byte blocks with 8 index bits, so every run is empty
		pal(8'h00, 16'h1234);
		pal(8'hFF, 16'hFFFF);
		pal(8'h01, 16'h0000);
		pal(8'h80, 16'h80C1);
		stream(8'h00, 1'b0);
		stream(8'hFF, 1'b1);

		// no index bits: whole byte is the count
		set_mode(4'd0, 1'b0);
		stream(8'h01, 1'b0);
		stream(8'h04, 1'b0);
		stream(8'h05, 1'b0);
		stream(8'hFF, 1'b0);
		stream(8'h00, 1'b1);

		set_mode(4'd1, 1'b0);
		stream(8'h03, 1'b0);
		stream(8'hFE, 1'b0);

		// two-byte blocks: dropped first byte, palette write inside a pair, longest run
		set_mode(4'd8, 1'b1);
		stream(8'h02, 1'b0);
		stream(8'hFF, 1'b0);
		stream(8'h00, 1'b1);
		stream(8'h03, 1'b0);
		pal(8'h03, 16'hBEEF);
		stream(8'h03, 1'b0);
		stream(8'hFF, 1'b0);
		stream(8'h00, 1'b0);
		stream(8'h05, 1'b0);

		// pending high byte dropped by the switch to one-byte blocks
		set_mode(4'd4, 1'b1);
		stream(8'h31, 1'b0);

		// index width above 8 still selects two-byte blocks
		set_mode(4'd12, 1'b1);
		stream(8'h01, 1'b0);
		stream(8'h80, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			set_mode(PHASE_BITS[p], PHASE_COMP[p]);
			gaps_on = (p != HOLD_PHASE) && (p != 5);
			if (p == HOLD_PHASE)
				hold_req <= 1'b1;
			burst_left = 0;
			repeat (ITEMS_PER_PHASE) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(12, 1);
					if (gaps_on) begin
						in_valid <= 1'b0;
						repeat ($urandom_range(8, 1)) @(posedge clk);
					end
				end
				burst_left--;
				random_request();
			end
		end

		wait_idle();
		if (fail_count == 0 && pending_groups == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/prlpd_pkg.sv
rtl/prlpd_palette_ram.sv
rtl/prlpd_run_seq.sv
rtl/palette_run_length_pixel_decoder_top.sv
tb/palette_run_length_pixel_decoder_checker.sv
tb/palette_run_length_pixel_decoder_top_tb.sv
